// ----- hw/rtl/rars_pkg.sv -----
// ----------------------------------------------------------------------------
// rars_pkg
// shared constants for the range add / range sum tree
// ----------------------------------------------------------------------------
`default_nettype none

package rars_pkg;

	localparam int unsigned LEAVES_DEF       = 1024;
	localparam int unsigned LEAF_COUNT_RESET = 1024;

	localparam int unsigned SUM_W   = 64;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned FIRST_W = 11;
	localparam int unsigned LAST_W  = 10;
	localparam int unsigned CFG_W   = 11;

	// one memory word holds both prefix trees
	localparam int unsigned WORD_W = 2 * SUM_W;

	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_SUM = 1'b1;

endpackage : rars_pkg

`default_nettype wire

// ----- hw/rtl/rars_ram.sv -----
// ----------------------------------------------------------------------------
// rars_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rars_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule : rars_ram

`default_nettype wire

// ----- hw/rtl/range_add_range_sum_tree.sv -----
// ----------------------------------------------------------------------------
// range_add_range_sum_tree
// range add / range sum over leaf positions, kept as two binary indexed
// prefix trees in one memory; each tree step is a read then write or accumulate
//
//  channel  | signals                                         | dir
//  ---------+-------------------------------------------------+----
//  item     | start, busy, func, range_first, range_last,     | in
//           | add_value (busy is out)                         |
//  result   | done, range_sum                                 | out
//  config   | cfg_we, cfg_wdata (leaf_count)                  | in
//
// an item is taken when start is high and busy is low
// add: a multiply step, then a read and write per tree node on up to two walks
// sum: a read and an accumulate per tree node on two walks, each closed by a
// multiply step; all walks share the single memory port; an empty range
// never raises busy; after reset and each config write busy stays high
// while the memory is cleared; done is a one cycle strobe, never stalled
// ----------------------------------------------------------------------------
`default_nettype none

module range_add_range_sum_tree
	import rars_pkg::*;
#(
	parameter int unsigned LEAVES = LEAVES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      func,
	input  wire logic [FIRST_W-1:0]        range_first,
	input  wire logic [LAST_W-1:0]         range_last,
	input  wire logic signed [VAL_W-1:0]   add_value,
	output logic                           done,
	output logic signed [SUM_W-1:0]        range_sum,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_W-1:0]          cfg_wdata
);

	localparam int unsigned AW = $clog2(LEAVES);
	localparam int unsigned IW = $clog2(LEAVES) + 2;
	localparam int unsigned CW = (IW > 12) ? IW : 12;
	localparam int unsigned PW = VAL_W + IW + 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_UPD_RD,
		S_UPD_WR,
		S_QRY_RD,
		S_QRY_ACC,
		S_QRY_MUL
	} state_t;

	function automatic logic [IW-1:0] clamp_n(input logic [CFG_W-1:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		if (w == '0) begin
			return IW'(1);
		end else if (w > CW'(LEAVES)) begin
			return IW'(LEAVES);
		end
		return IW'(w);
	endfunction

	state_t                  state_q;
	logic [AW-1:0]           clr_q;
	logic [IW-1:0]           n_q;
	logic signed [VAL_W-1:0] val_q;
	logic [IW-1:0]           l_q;
	logic [IW-1:0]           r_q;
	logic [IW-1:0]           i_q;
	logic                    phase_q;
	logic signed [SUM_W-1:0] prod_lo_q;
	logic signed [SUM_W-1:0] prod_hi_q;
	logic [SUM_W-1:0]        acc1_q;
	logic [SUM_W-1:0]        acc2_q;
	logic [SUM_W-1:0]        qprod_q;
	logic [SUM_W-1:0]        pr_q;
	logic                    qsub_q;
	logic                    done_q;
	logic [SUM_W-1:0]        sum_q;

	logic [CW-1:0]    fst, lst, nm1, lastc;
	logic             empty;
	logic [IW-1:0]    lowbit;
	logic [IW-1:0]    i_m1;
	logic [SUM_W-1:0] d1, d2;
	logic signed [PW-1:0] m_lo, m_hi;
	logic [SUM_W-1:0] pfx;

	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	// input range clipped to the leaves in use
	assign fst   = CW'(range_first);
	assign lst   = CW'(range_last);
	assign nm1   = CW'(n_q) - CW'(1);
	assign lastc = (lst > nm1) ? nm1 : lst;
	assign empty = fst > lastc;

	assign lowbit = i_q & (~i_q + IW'(1));
	assign i_m1   = i_q - IW'(1);

	assign m_lo = PW'(val_q) * $signed({1'b0, l_q - IW'(1)});
	assign m_hi = PW'(val_q) * $signed({1'b0, r_q});

	assign d1 = phase_q ? -SUM_W'(val_q) : SUM_W'(val_q);
	assign d2 = phase_q ? -prod_hi_q : prod_lo_q;

	assign pfx = qprod_q - acc2_q;

	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_UPD_WR);
	assign ram_addr  = (state_q == S_CLEAR) ? clr_q : i_m1[AW-1:0];
	assign ram_wdata = (state_q == S_CLEAR) ? '0 :
		{ram_rdata[WORD_W-1:SUM_W] + d2, ram_rdata[SUM_W-1:0] + d1};

	rars_ram #(
		.WIDTH (WORD_W),
		.DEPTH (LEAVES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			n_q     <= clamp_n(CFG_W'(LEAF_COUNT_RESET));
			done_q  <= 1'b0;
			qsub_q  <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(LEAVES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						val_q   <= add_value;
						l_q     <= IW'(fst + CW'(1));
						r_q     <= IW'(lastc + CW'(1));
						phase_q <= 1'b0;
						acc1_q  <= '0;
						acc2_q  <= '0;
						if (empty) begin
							if (func == FUNC_SUM) begin
								done_q <= 1'b1;
								sum_q  <= '0;
							end
						end else if (func == FUNC_SUM) begin
							i_q     <= IW'(lastc + CW'(1));
							qsub_q  <= 1'b0;
							state_q <= S_QRY_RD;
						end else begin
							i_q     <= IW'(fst + CW'(1));
							state_q <= S_PREP;
						end
					end
				end
				S_PREP: begin
					prod_lo_q <= SUM_W'(m_lo);
					prod_hi_q <= SUM_W'(m_hi);
					state_q   <= S_UPD_RD;
				end
				S_UPD_RD: begin
					if (i_q > n_q) begin
						if (!phase_q && (r_q < n_q)) begin
							phase_q <= 1'b1;
							i_q     <= r_q + IW'(1);
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_UPD_WR;
					end
				end
				S_UPD_WR: begin
					i_q     <= i_q + lowbit;
					state_q <= S_UPD_RD;
				end
				S_QRY_RD: begin
					if (qsub_q) begin
						// prefix = b1 * x - b2
						qsub_q <= 1'b0;
						acc1_q <= '0;
						acc2_q <= '0;
						if (!phase_q) begin
							pr_q    <= pfx;
							phase_q <= 1'b1;
							i_q     <= l_q - IW'(1);
						end else begin
							done_q  <= 1'b1;
							sum_q   <= pr_q - pfx;
							state_q <= S_IDLE;
						end
					end else if (i_q == '0) begin
						state_q <= S_QRY_MUL;
					end else begin
						state_q <= S_QRY_ACC;
					end
				end
				S_QRY_ACC: begin
					acc1_q  <= acc1_q + ram_rdata[SUM_W-1:0];
					acc2_q  <= acc2_q + ram_rdata[WORD_W-1:SUM_W];
					i_q     <= i_q - lowbit;
					state_q <= S_QRY_RD;
				end
				S_QRY_MUL: begin
					qprod_q <= acc1_q * SUM_W'(phase_q ? (l_q - IW'(1)) : r_q);
					qsub_q  <= 1'b1;
					state_q <= S_QRY_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_we) begin
				n_q     <= clamp_n(cfg_wdata);
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign range_sum = sum_q;

endmodule : range_add_range_sum_tree

`default_nettype wire

// ----- tb/range_add_range_sum_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_add_range_sum_checker
// watches the item, result and config channels of the range add / range sum
// tree, keeps a flat copy of the leaf values, predicts each range sum and
// compares it with the sum that comes back
// ----------------------------------------------------------------------------
module range_add_range_sum_checker
	import rars_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic                    busy,
	input  wire logic                    func,
	input  wire logic [FIRST_W-1:0]      range_first,
	input  wire logic [LAST_W-1:0]       range_last,
	input  wire logic signed [VAL_W-1:0] add_value,
	input  wire logic                    done,
	input  wire logic signed [SUM_W-1:0] range_sum,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_W-1:0]        cfg_wdata,
	output int                           fail_count,
	output int                           sums_waiting
);

	logic [SUM_W-1:0] leaf_value [LEAVES_DEF];
	logic [SUM_W-1:0] sum_queue [$];
	int unsigned      leaves_used;

	function automatic int unsigned clip_count(logic [CFG_W-1:0] v);
		if (v == 0) begin
			return 1;
		end
		if (v > LEAVES_DEF) begin
			return LEAVES_DEF;
		end
		return int'(v);
	endfunction

	task automatic clear_leaves();
		foreach (leaf_value[i]) leaf_value[i] = '0;
	endtask

	task automatic report(string what, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic apply_item(logic f, int unsigned first, int unsigned last,
			logic signed [VAL_W-1:0] v);
		logic [SUM_W-1:0] total;
		logic [SUM_W-1:0] ext;
		total = '0;
		ext = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
		for (int unsigned i = first; i <= last && i < leaves_used; i++) begin
			if (f == FUNC_ADD) begin
				leaf_value[i] += ext;
			end else begin
				total += leaf_value[i];
			end
		end
		if (f == FUNC_SUM) begin
			sum_queue = {sum_queue, total};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_leaves();
			sum_queue.delete();
			leaves_used = LEAF_COUNT_RESET;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				leaves_used = clip_count(cfg_wdata);
				clear_leaves();
			end
			if (done) begin
				if (sum_queue.size() == 0) begin
					report("unexpected sum", range_sum, '0);
				end else if (range_sum !== sum_queue[0]) begin
					report("range_sum", range_sum, sum_queue.pop_front());
				end else begin
					void'(sum_queue.pop_front());
				end
			end
			if (start && !busy) begin
				apply_item(func, range_first, range_last, add_value);
			end
		end
		sums_waiting = sum_queue.size();
	end

endmodule

// ----- tb/range_add_range_sum_tree_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_tb
// drives directed and random range add / range sum items through the tree
// over several leaf counts, with random idle bursts; the checker predicts
// and compares every sum
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_tb;
	import rars_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    func;
	logic [FIRST_W-1:0]      range_first;
	logic [LAST_W-1:0]       range_last;
	logic signed [VAL_W-1:0] add_value;
	logic                    done;
	logic signed [SUM_W-1:0] range_sum;
	logic                    cfg_we;
	logic [CFG_W-1:0]        cfg_wdata;
	int                      fail_count;
	int                      sums_waiting;
	int                      cycle_count;
	int unsigned             leaves_now;
	bit                      allow_idle;

	range_add_range_sum_tree dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.range_first(range_first), .range_last(range_last), .add_value(add_value),
		.done(done), .range_sum(range_sum), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	range_add_range_sum_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.range_first(range_first), .range_last(range_last), .add_value(add_value),
		.done(done), .range_sum(range_sum), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .sums_waiting(sums_waiting)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic wait_ready();
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_item(logic f, int unsigned first, int unsigned last, int unsigned v);
		bit taken;
		if (allow_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		range_first <= FIRST_W'(first);
		range_last <= LAST_W'(last);
		add_value <= v;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sums_waiting != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_leaf_count(int unsigned v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
		wait_ready();
		leaves_now = (v == 0) ? 1 : (v > LEAVES_DEF) ? LEAVES_DEF : v;
	endtask

	function automatic int unsigned pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	function automatic int unsigned pick_pos(int unsigned n);
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1024);
			1: return n - 1;
			2: return 0;
			default: return $urandom_range(0, n - 1);
		endcase
	endfunction

	task automatic random_items(int count);
		int unsigned a;
		int unsigned b;
		for (int k = 0; k < count; k++) begin
			a = pick_pos(leaves_now);
			b = pick_pos(leaves_now);
			if ($urandom_range(0, 7) != 0 && a > b) begin
				{a, b} = {b, a};
			end
			if (b > 1023) begin
				b = 1023;
			end
			send_item($urandom_range(0, 1), a, b, pick_value());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_ADD;
		range_first = '0;
		range_last = '0;
		add_value = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cycle_count = 0;
		leaves_now = LEAF_COUNT_RESET;
		allow_idle = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		wait_ready();

		send_item(FUNC_SUM, 0, 1023, 0);
		send_item(FUNC_ADD, 0, 1023, 32'h7fff_ffff);
		send_item(FUNC_SUM, 0, 1023, 0);
		send_item(FUNC_ADD, 0, 1023, 32'h8000_0000);
		send_item(FUNC_SUM, 0, 1023, 0);
		send_item(FUNC_ADD, 0, 0, 32'hffff_ffff);
		send_item(FUNC_ADD, 1023, 1023, 5);
		send_item(FUNC_SUM, 0, 0, 0);
		send_item(FUNC_SUM, 1023, 1023, 0);
		send_item(FUNC_ADD, 700, 3, 99);
		send_item(FUNC_SUM, 700, 3, 0);
		send_item(FUNC_SUM, 1024, 1023, 0);
		send_item(FUNC_ADD, 1024, 1023, 7);
		send_item(FUNC_ADD, 341, 682, 32'h1234_5678);
		send_item(FUNC_SUM, 300, 700, 0);
		send_item(FUNC_SUM, 0, 1023, 0);

		allow_idle = 1'b1;
		random_items(100);
		write_leaf_count(1);
		send_item(FUNC_ADD, 0, 1023, 32'h7fff_ffff);
		send_item(FUNC_SUM, 0, 0, 0);
		send_item(FUNC_SUM, 1, 1023, 0);
		random_items(30);
		write_leaf_count(0);
		random_items(30);
		write_leaf_count(2047);
		random_items(80);
		drain();
		write_leaf_count(7);
		random_items(80);
		write_leaf_count(100);
		random_items(100);
		write_leaf_count(1024);
		random_items(80);
		allow_idle = 1'b0;
		random_items(80);
		start <= 1'b0;
		@(posedge clk);
		while (sums_waiting != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
